@@ rtl/pale_pkg.sv @@
// ----------------------------------------------------------------------------
// pale_pkg
// Shared types, codes and widths of the positional array list engine.
// ----------------------------------------------------------------------------
package pale_pkg;

   localparam int WORD_W       = 32;
   localparam int CMD_W        = 3;
   localparam int POS_W        = 5;
   localparam int STATUS_W     = 2;
   localparam int DEF_CAPACITY = 16;

   typedef logic signed [WORD_W-1:0] word_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR    = 3'd0,
      CMD_INSERT   = 3'd1,
      CMD_DELETE   = 3'd2,
      CMD_LOCATE   = 3'd3,
      CMD_RETRIEVE = 3'd4,
      CMD_SORTED   = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BADPOS  = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_MISSING = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_SHIFT_UP,
      CELL_SHIFT_DOWN
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        hit_load;
      logic        hit_shift;
      logic        find_ge;
      logic        live;
   } cell_ctl_type;

   typedef struct packed {
      logic ins_en;
      logic del_en;
      logic hit_load;
      logic hit_shift;
      logic find_ge;
   } list_ctl_type;

endpackage

@@ rtl/pale_cell.sv @@
// ----------------------------------------------------------------------------
// pale_cell
// One list slot: holds an entry and a search flag, moves both to neighbors.
// ----------------------------------------------------------------------------
module pale_cell (
   input  logic                  clock,
   input  pale_pkg::cell_ctl_type ctl,
   input  pale_pkg::word_type    word,
   input  pale_pkg::word_type    prev_entry,
   input  pale_pkg::word_type    next_entry,
   input  logic                  next_hit,
   output pale_pkg::word_type    entry,
   output logic                  hit
);
   import pale_pkg::*;

   word_type entry_ff, entry_in;
   logic     hit_ff, hit_in;
   logic     match, less, flag;

   assign match = (entry_ff == word);
   assign less  = (entry_ff < word);
   assign flag  = ctl.find_ge ? !less : match;

   always_comb begin
      case (ctl.op)
         CELL_WRITE:      entry_in = word;
         CELL_SHIFT_UP:   entry_in = prev_entry;
         CELL_SHIFT_DOWN: entry_in = next_entry;
         default:         entry_in = entry_ff;
      endcase
   end

   always_comb begin
      if (ctl.hit_load) begin
         hit_in = ctl.live && flag;
      end else if (ctl.hit_shift) begin
         hit_in = next_hit;
      end else begin
         hit_in = hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      hit_ff   <= hit_in;
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;

endmodule

@@ rtl/pale_ctrl.sv @@
// ----------------------------------------------------------------------------
// pale_ctrl
// Command sequencer: fill count, scan walk, edit control and result register.
// ----------------------------------------------------------------------------
module pale_ctrl #(
   parameter  int CAPACITY = pale_pkg::DEF_CAPACITY,
   localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [pale_pkg::CMD_W-1:0]      req_command,
   input  pale_pkg::word_type              req_value,
   input  logic [pale_pkg::POS_W-1:0]      req_position,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [pale_pkg::STATUS_W-1:0]   rsp_status,
   output pale_pkg::word_type              rsp_read_value,
   output logic [pale_pkg::POS_W-1:0]      rsp_found_position,
   output logic [pale_pkg::POS_W-1:0]      rsp_entry_count,
   input  logic                            hit_head,
   input  pale_pkg::word_type              read_word,
   output pale_pkg::list_ctl_type          list_ctl,
   output logic [CNT_W-1:0]                edit_at,
   output pale_pkg::word_type              edit_word,
   output logic [CNT_W-1:0]                list_count
);
   import pale_pkg::*;

   localparam int              CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   cmd_type            cmd_ff, cmd_in;
   word_type           value_ff, value_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   word_type           rsp_read_value_ff, rsp_read_value_in;
   logic [POS_W-1:0]   rsp_found_position_ff, rsp_found_position_in;
   logic [POS_W-1:0]   rsp_entry_count_ff, rsp_entry_count_in;

   cmd_type            req_cmd;
   logic               accept, out_free, scan_end, produce;
   status_type         status_new;
   word_type           read_new;
   logic [POS_W-1:0]   fpos_new;
   logic [CMP_W-1:0]   pos_x, count_x, idx_x, count_next_x;

   assign req_cmd      = cmd_type'(req_command);
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign req_stall    = (state_ff != ST_IDLE) || !out_free;
   assign accept       = req_valid && !req_stall;
   assign pos_x        = CMP_W'(req_position);
   assign count_x      = CMP_W'(count_ff);
   assign idx_x        = CMP_W'(idx_ff);
   assign count_next_x = CMP_W'(count_in);
   assign scan_end     = (idx_ff == count_ff) || hit_head;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      cmd_in     = cmd_ff;
      value_in   = value_ff;
      produce    = 1'b0;
      status_new = STATUS_OK;
      read_new   = '0;
      fpos_new   = '0;
      list_ctl   = '0;
      edit_at    = idx_ff;
      edit_word  = value_ff;
      case (state_ff)
         ST_IDLE: begin
            edit_word = req_value;
            edit_at   = pos_x[CNT_W-1:0];
            if (accept) begin
               cmd_in   = req_cmd;
               value_in = req_value;
               case (req_cmd)
                  CMD_CLEAR: begin
                     count_in = '0;
                     produce  = 1'b1;
                  end
                  CMD_INSERT: begin
                     produce = 1'b1;
                     if (pos_x > count_x) begin
                        status_new = STATUS_BADPOS;
                     end else if (count_ff == CAP_CNT) begin
                        status_new = STATUS_FULL;
                     end else begin
                        list_ctl.ins_en = 1'b1;
                        count_in        = count_ff + 1'b1;
                     end
                  end
                  CMD_DELETE: begin
                     produce = 1'b1;
                     if (pos_x >= count_x) begin
                        status_new = STATUS_BADPOS;
                     end else begin
                        list_ctl.del_en = 1'b1;
                        count_in        = count_ff - 1'b1;
                     end
                  end
                  CMD_LOCATE: begin
                     list_ctl.hit_load = 1'b1;
                     idx_in            = '0;
                     state_in          = ST_SCAN;
                  end
                  CMD_RETRIEVE: begin
                     produce = 1'b1;
                     if (pos_x >= count_x) begin
                        status_new = STATUS_BADPOS;
                     end else begin
                        read_new = read_word;
                     end
                  end
                  CMD_SORTED: begin
                     if (count_ff == CAP_CNT) begin
                        produce    = 1'b1;
                        status_new = STATUS_FULL;
                     end else begin
                        list_ctl.hit_load = 1'b1;
                        list_ctl.find_ge  = 1'b1;
                        idx_in            = '0;
                        state_in          = ST_SCAN;
                     end
                  end
                  default: begin
                     produce = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_end && out_free) begin
               produce  = 1'b1;
               state_in = ST_IDLE;
               if (cmd_ff == CMD_LOCATE) begin
                  if (hit_head) begin
                     fpos_new = idx_x[POS_W-1:0];
                  end else begin
                     status_new = STATUS_MISSING;
                  end
               end else begin
                  list_ctl.ins_en = 1'b1;
                  count_in        = count_ff + 1'b1;
                  fpos_new        = idx_x[POS_W-1:0];
               end
            end else if (!scan_end) begin
               list_ctl.hit_shift = 1'b1;
               idx_in             = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in          = produce || (rsp_valid_ff && rsp_stall);
   assign rsp_status_in         = produce ? status_new : rsp_status_ff;
   assign rsp_read_value_in     = produce ? read_new : rsp_read_value_ff;
   assign rsp_found_position_in = produce ? fpos_new : rsp_found_position_ff;
   assign rsp_entry_count_in    = produce ? count_next_x[POS_W-1:0] : rsp_entry_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff                <= idx_in;
      cmd_ff                <= cmd_in;
      value_ff              <= value_in;
      rsp_status_ff         <= rsp_status_in;
      rsp_read_value_ff     <= rsp_read_value_in;
      rsp_found_position_ff <= rsp_found_position_in;
      rsp_entry_count_ff    <= rsp_entry_count_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_read_value     = rsp_read_value_ff;
   assign rsp_found_position = rsp_found_position_ff;
   assign rsp_entry_count    = rsp_entry_count_ff;
   assign list_count         = count_ff;

endmodule

@@ rtl/positional_array_list_engine_top.sv @@
// Transfer to result: clear, insert at, delete at, retrieve, unused codes and a sorted
// insert into a full list register the result in the cycle after the transfer; locate
// and sorted insert walk the cell hit shift line to the found index (at most the fill
// count). The next transfer comes as early as the result; a held result stalls input.
// Reset clears the fill count and control; entries are not cleared.
// ----------------------------------------------------------------------------
// positional_array_list_engine_top
// Fixed-capacity ordered list of signed words held in a row of cells.
// ----------------------------------------------------------------------------
module positional_array_list_engine_top #(
   parameter int CAPACITY = pale_pkg::DEF_CAPACITY
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pale_pkg::CMD_W-1:0]    req_command,
   input  logic signed [pale_pkg::WORD_W-1:0] req_value,
   input  logic [pale_pkg::POS_W-1:0]    req_position,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pale_pkg::STATUS_W-1:0] rsp_status,
   output logic signed [pale_pkg::WORD_W-1:0] rsp_read_value,
   output logic [pale_pkg::POS_W-1:0]    rsp_found_position,
   output logic [pale_pkg::POS_W-1:0]    rsp_entry_count
);
   import pale_pkg::*;

   localparam int               CNT_W   = $clog2(CAPACITY + 1);
   localparam int               RD_N    = (CAPACITY < (2 ** POS_W)) ? CAPACITY : (2 ** POS_W);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   list_ctl_type     list_ctl;
   logic [CNT_W-1:0] edit_at;
   word_type         edit_word;
   logic [CNT_W-1:0] list_count;
   word_type         read_word;
   word_type         cell_entry [CAPACITY];
   logic             cell_hit   [CAPACITY];
   cell_ctl_type     cell_ctl   [CAPACITY];

   pale_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_value          (req_value),
      .req_position       (req_position),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_read_value     (rsp_read_value),
      .rsp_found_position (rsp_found_position),
      .rsp_entry_count    (rsp_entry_count),
      .hit_head           (cell_hit[0]),
      .read_word          (read_word),
      .list_ctl           (list_ctl),
      .edit_at            (edit_at),
      .edit_word          (edit_word),
      .list_count         (list_count)
   );

   always_comb begin
      read_word = '0;
      for (int k = 0; k < RD_N; k++) begin
         if (req_position == POS_W'(k)) begin
            read_word = cell_entry[k];
         end
      end
   end

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      word_type prev_entry;
      word_type next_entry;
      logic     next_hit;

      if (k == 0) begin : g_first
         assign prev_entry = edit_word;
      end else begin : g_mid_prev
         assign prev_entry = cell_entry[k-1];
      end

      if (k == CAPACITY - 1) begin : g_last
         assign next_entry = cell_entry[k];
         assign next_hit   = 1'b0;
      end else begin : g_mid_next
         assign next_entry = cell_entry[k+1];
         assign next_hit   = cell_hit[k+1];
      end

      always_comb begin
         cell_ctl[k].hit_load  = list_ctl.hit_load;
         cell_ctl[k].hit_shift = list_ctl.hit_shift;
         cell_ctl[k].find_ge   = list_ctl.find_ge;
         cell_ctl[k].live      = CNT_W'(k) < list_count;
         if (list_ctl.ins_en && (CNT_W'(k) == edit_at)) begin
            cell_ctl[k].op = CELL_WRITE;
         end else if (list_ctl.ins_en && (CNT_W'(k) > edit_at)) begin
            cell_ctl[k].op = CELL_SHIFT_UP;
         end else if (list_ctl.del_en && (CNT_W'(k) >= edit_at)) begin
            cell_ctl[k].op = CELL_SHIFT_DOWN;
         end else begin
            cell_ctl[k].op = CELL_HOLD;
         end
      end

      pale_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[k]),
         .word       (edit_word),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .next_hit   (next_hit),
         .entry      (cell_entry[k]),
         .hit        (cell_hit[k])
      );
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      list_count <= CAP_CNT)
      else $error("fill count above capacity");

   a_edit_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(list_ctl.ins_en && list_ctl.del_en))
      else $error("insert and delete in the same cycle");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      list_ctl.ins_en |=> (list_count == $past(list_count) + 1'b1))
      else $error("insert did not grow the list by one");

   a_load_on_transfer: assert property (@(posedge clock) disable iff (reset)
      list_ctl.hit_load |-> (req_valid && !req_stall))
      else $error("search flags loaded without an input transfer");

   a_held_result_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("input taken while a result is held");
`endif

endmodule
